/* design/sha512_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types, constants and the rotate helper for the SHA-512 digest core.
// ----------------------------------------------------------------------------
package sha512_pkg;

    typedef struct packed {
        logic [63:0] msg_word;
        logic [3:0]  word_bytes;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_end;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_INIT,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    // Padding phase of the final item
    typedef enum logic [2:0] {
        PH_DATA,   // captured message word
        PH_PAD,    // separate pad word after a full final word
        PH_ZFILL,  // zero fill up to the length slot
        PH_ZERO,   // high half of the bit length
        PH_LEN,    // low half of the bit length
        PH_DONE
    } t_phase;

    // Source selector for a word pushed into the block buffer
    typedef enum logic [1:0] {
        SRC_MSG,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN
    } t_src;

    // Controller to datapath
    typedef struct packed {
        logic       capture;  // latch input item, update byte count
        logic       push;     // write one word into the block buffer
        t_src       src;
        logic       init;     // working vars <= chain hash
        logic       round;    // one compression round
        logic       fold;     // chain hash += working vars
        logic       restart;  // return to initial values
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [4:0] fill;
        logic [6:0] rnd;
        logic       full_last; // captured word had 8 bytes (also set for a non-final word)
    } t_status;

    localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;
    localparam int unsigned LEN_WORD = 14;
    localparam int unsigned ROUNDS   = 80;

    localparam logic [63:0] H0 [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [63:0] ror(input logic [63:0] v, input int unsigned r);
        ror = (v >> r) | (v << (64 - r));
    endfunction

endpackage

/* design/sha512_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512_ctrl
// Sequencer: word pushes, padding, 80-round compression and digest output.
// ----------------------------------------------------------------------------
module sha512_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_last,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [2:0]          o_emit_idx,
    output sha512_pkg::t_cmd    o_cmd,
    input  sha512_pkg::t_status i_sts
);

    sha512_pkg::t_state r_state, n_state;
    logic               r_last, n_last;
    // padding phase: data, pad word, zero fill, zero, length, done
    sha512_pkg::t_phase r_phase, n_phase;
    logic [2:0]         r_idx, n_idx;
    logic               block_full;

    assign block_full = (i_sts.fill == 5'd16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha512_pkg::ST_IDLE;
            r_last  <= 1'b0;
            r_phase <= sha512_pkg::PH_DATA;
            r_idx   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        n_phase = r_phase;
        n_idx   = r_idx;
        case (r_state)
            sha512_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = sha512_pkg::ST_PUSH;
                    n_last  = i_in_last;
                    n_phase = sha512_pkg::PH_DATA;
                end
            end
            sha512_pkg::ST_PUSH: begin
                // one push this cycle; decide what follows
                if (!r_last) begin
                    n_phase = sha512_pkg::PH_DONE;
                end else begin
                    case (r_phase)
                        sha512_pkg::PH_DATA:
                            n_phase = i_sts.full_last ? sha512_pkg::PH_PAD
                                                      : sha512_pkg::PH_ZFILL;
                        sha512_pkg::PH_PAD:  n_phase = sha512_pkg::PH_ZFILL;
                        sha512_pkg::PH_ZFILL:
                            n_phase = (i_sts.fill == 5'd13) ? sha512_pkg::PH_ZERO
                                                            : sha512_pkg::PH_ZFILL;
                        sha512_pkg::PH_ZERO: n_phase = sha512_pkg::PH_LEN;
                        default:             n_phase = sha512_pkg::PH_DONE;
                    endcase
                    // zero fill: after this push, is fill 14?
                    if (r_phase == sha512_pkg::PH_DATA && !i_sts.full_last
                        && i_sts.fill == 5'd13)
                        n_phase = sha512_pkg::PH_ZERO;
                    if (r_phase == sha512_pkg::PH_PAD && i_sts.fill == 5'd13)
                        n_phase = sha512_pkg::PH_ZERO;
                end
                if (i_sts.fill == 5'd15)
                    n_state = sha512_pkg::ST_INIT;
                else if (n_phase == sha512_pkg::PH_DONE)
                    n_state = r_last ? sha512_pkg::ST_EMIT : sha512_pkg::ST_IDLE;
                n_idx = 3'd0;
            end
            sha512_pkg::ST_INIT:  n_state = sha512_pkg::ST_ROUND;
            sha512_pkg::ST_ROUND: begin
                if (i_sts.rnd == 7'(sha512_pkg::ROUNDS - 1))
                    n_state = sha512_pkg::ST_FOLD;
            end
            sha512_pkg::ST_FOLD: begin
                if (r_phase != sha512_pkg::PH_DONE)
                    n_state = sha512_pkg::ST_PUSH;
                else
                    n_state = r_last ? sha512_pkg::ST_EMIT : sha512_pkg::ST_IDLE;
            end
            sha512_pkg::ST_EMIT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7)
                        n_state = sha512_pkg::ST_IDLE;
                end
            end
            default: n_state = sha512_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_cmd.src   = sha512_pkg::SRC_MSG;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_emit_idx  = r_idx;
        case (r_state)
            sha512_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            sha512_pkg::ST_PUSH: begin
                o_cmd.push = !block_full;
                case (r_phase)
                    sha512_pkg::PH_DATA: o_cmd.src = sha512_pkg::SRC_MSG;
                    sha512_pkg::PH_PAD:  o_cmd.src = sha512_pkg::SRC_PAD;
                    sha512_pkg::PH_LEN:  o_cmd.src = sha512_pkg::SRC_LEN;
                    default:             o_cmd.src = sha512_pkg::SRC_ZERO;
                endcase
            end
            sha512_pkg::ST_INIT:  o_cmd.init  = 1'b1;
            sha512_pkg::ST_ROUND: o_cmd.round = 1'b1;
            sha512_pkg::ST_FOLD:  o_cmd.fold  = 1'b1;
            sha512_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.restart = i_out_ready && (r_idx == 3'd7);
            end
            default: ;
        endcase
    end

endmodule

/* design/sha512_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512_dp
// Datapath: block buffer / schedule window, round registers, chain hash.
// ----------------------------------------------------------------------------
module sha512_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha512_pkg::t_in_item i_item,
    input  sha512_pkg::t_cmd     i_cmd,
    input  logic [2:0]           i_emit_idx,
    output logic [63:0]          o_digest,
    output sha512_pkg::t_status  o_sts
);

    logic [63:0] r_h [8];
    logic [63:0] r_v [8];
    logic [63:0] r_w [16];
    logic [60:0] r_cnt;
    logic [4:0]  r_fill;
    logic [6:0]  r_rnd;
    logic [63:0] r_word;  // captured word, already padded when final and short
    logic        r_full;

    logic [3:0]  nb;
    logic [63:0] keep, padw, push_val, wt, w2, w7, w15, w16, t1, t2, s1, s0, chv, mj;
    logic [3:0]  ti;

    // clamp and mask the final word
    always_comb begin
        nb = i_item.last_word ? ((i_item.word_bytes > 4'd8) ? 4'd8 : i_item.word_bytes)
                              : 4'd8;
        keep = (nb == 4'd0) ? 64'd0 : (~64'd0 << (7'd64 - {nb[3:0], 3'b000}));
        padw = (nb == 4'd8) ? i_item.msg_word
             : ((i_item.msg_word & keep) | (sha512_pkg::PAD_WORD >> {nb[2:0], 3'b000}));
    end

    always_comb begin
        case (i_cmd.src)
            sha512_pkg::SRC_MSG:  push_val = r_word;
            sha512_pkg::SRC_PAD:  push_val = sha512_pkg::PAD_WORD;
            sha512_pkg::SRC_LEN:  push_val = {r_cnt, 3'b000};
            default:              push_val = 64'd0;
        endcase
    end

    // message schedule word and round terms for this round
    always_comb begin
        ti  = r_rnd[3:0];
        w2  = r_w[ti - 4'd2];
        w7  = r_w[ti - 4'd7];
        w15 = r_w[ti - 4'd15];
        w16 = r_w[ti];
        if (r_rnd < 7'd16)
            wt = w16;
        else
            wt = (sha512_pkg::ror(w2, 19) ^ sha512_pkg::ror(w2, 61) ^ (w2 >> 6)) + w7
               + (sha512_pkg::ror(w15, 1) ^ sha512_pkg::ror(w15, 8) ^ (w15 >> 7)) + w16;
        s1  = sha512_pkg::ror(r_v[4], 14) ^ sha512_pkg::ror(r_v[4], 18)
            ^ sha512_pkg::ror(r_v[4], 41);
        chv = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1  = r_v[7] + s1 + chv + sha512_pkg::ROUND_K[r_rnd] + wt;
        s0  = sha512_pkg::ror(r_v[0], 28) ^ sha512_pkg::ror(r_v[0], 34)
            ^ sha512_pkg::ror(r_v[0], 39);
        mj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2  = s0 + mj;
    end

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_cnt  <= '0;
            r_fill <= '0;
            r_rnd  <= '0;
            r_full <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_cnt  <= r_cnt + 61'(nb);
                r_full <= (nb == 4'd8);
            end
            if (i_cmd.push)
                r_fill <= r_fill + 5'd1;
            if (i_cmd.round)
                r_rnd <= r_rnd + 7'd1;
            if (i_cmd.fold) begin
                r_rnd  <= '0;
                r_fill <= '0;
            end
        end
    end

    // chain hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < 8; i++) r_h[i] <= sha512_pkg::H0[i];
        end else if (i_cmd.fold) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture)
            r_word <= padw;
        if (i_cmd.push)
            r_w[r_fill[3:0]] <= push_val;
        if (i_cmd.round && r_rnd >= 7'd16)
            r_w[ti] <= wt;
        if (i_cmd.init) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_digest      = r_h[i_emit_idx];
    assign o_sts.fill    = r_fill;
    assign o_sts.rnd     = r_rnd;
    assign o_sts.full_last = r_full;

endmodule

/* design/sha512_message_digest_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512_message_digest_core
// SHA-512 hash of a word stream, one round per clock.
// ----------------------------------------------------------------------------
// Usage: message items (64-bit word, valid byte count, last flag) enter on the
// i_in_valid / o_in_ready channel, one at a time. A non-final item is captured
// and pushed; when it fills a 16-word block, the block is compressed (load,
// rounds and fold of the 64-bit round unit) before the next item is taken.
// The final item runs padding and length words, one per cycle outside its
// one or two compressions, then the eight digest words leave on o_out_valid /
// i_out_ready with word_index 0..7, digest_end on the last. While the receiver
// stalls the digest word holds and no input is taken. After the eighth word the
// core is back at the initial hash, ready for the next message.
// Reset (i_rst_n low, synchronous) loads the initial hash and clears counts;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module sha512_message_digest_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sha512_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sha512_pkg::t_out_item o_out_item
);

    sha512_pkg::t_cmd    cmd;
    sha512_pkg::t_status sts;
    logic [2:0]          emit_idx;
    logic [63:0]         digest;

    sha512_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_item.last_word),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_emit_idx  (emit_idx),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    sha512_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_in_item),
        .i_cmd      (cmd),
        .i_emit_idx (emit_idx),
        .o_digest   (digest),
        .o_sts      (sts)
    );

    assign o_out_item.digest_word = digest;
    assign o_out_item.word_index  = emit_idx;
    assign o_out_item.digest_end  = (emit_idx == 3'd7);

    // no input taken while a digest is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input and output overlap");

    // fill never passes a full block
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.fill <= 5'd16) else $error("block fill overflow");

    // stalled digest word index holds
    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(emit_idx))
        else $error("digest index moved under stall");

endmodule
